[hw/rtl/audio_channel_remix_saturating_assert.svh]
// assertion macros for the remix rtl
`ifndef AUDIO_CHANNEL_REMIX_SATURATING_ASSERT_SVH
`define AUDIO_CHANNEL_REMIX_SATURATING_ASSERT_SVH

// condition implies consequence in the same cycle
`define ACRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define ACRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/acrs_pkg.sv]
// types, constants and helpers for the channel remix block
`timescale 1ns / 1ps

package acrs_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int NUM_CH      = 6;
    localparam int CNT_BITS    = 3;

    localparam logic signed [SAMPLE_BITS-1:0] CLAMP_HI = 16'sh7fff;
    localparam logic signed [SAMPLE_BITS-1:0] CLAMP_LO = -16'sh7fff;

    // register indexes on the configuration port
    localparam logic REG_MIX_MODE   = 1'b0;
    localparam logic REG_SOURCE_CH  = 1'b1;

    localparam logic [CNT_BITS-1:0] CNT_MIN    = 3'd1;
    localparam logic [CNT_BITS-1:0] CNT_STEREO = 3'd2;
    localparam logic [CNT_BITS-1:0] CNT_DOWN   = 3'd5;
    localparam logic [CNT_BITS-1:0] CNT_MAX    = 3'd6;

    typedef enum logic [1:0] {
        MODE_DOWNMIX = 2'd0,
        MODE_COPY    = 2'd1,
        MODE_UPMIX   = 2'd2
    } mode_e;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t in_ch0;
        sample_t in_ch1;
        sample_t in_ch2;
        sample_t in_ch3;
        sample_t in_ch4;
        sample_t in_ch5;
        logic    silent_frame;
        logic    last_in_block;
    } in_item_t;

    typedef struct packed {
        sample_t               out_ch0;
        sample_t               out_ch1;
        sample_t               out_ch2;
        sample_t               out_ch3;
        sample_t               out_ch4;
        sample_t               out_ch5;
        logic [CNT_BITS-1:0]   out_channel_count;
        logic                  last_out_block;
    } out_item_t;

    // decoded per-frame control, travels down the pipe with the samples
    typedef struct packed {
        mode_e                 eff;
        logic [NUM_CH-1:0]     copy_mask;
        logic                  add_s5;
        logic [CNT_BITS-1:0]   cnt;
    } ctrl_t;

    // one saturating addition, result clamped to the symmetric range
    function automatic sample_t sat_add(input sample_t a, input sample_t b);
        logic signed [SAMPLE_BITS:0] sum;
        logic signed [SAMPLE_BITS:0] hi;
        logic signed [SAMPLE_BITS:0] lo;
        sample_t res;
        hi  = (SAMPLE_BITS+1)'(CLAMP_HI);
        lo  = (SAMPLE_BITS+1)'(CLAMP_LO);
        sum = signed'({a[SAMPLE_BITS-1], a}) + signed'({b[SAMPLE_BITS-1], b});
        if (sum > hi)
            res = CLAMP_HI;
        else if (sum < lo)
            res = CLAMP_LO;
        else
            res = sum[SAMPLE_BITS-1:0];
        return res;
    endfunction

endpackage

[hw/rtl/acrs_mix_pipe.sv]
// three-stage remix datapath with valid/ready flow control
`timescale 1ns / 1ps
`include "audio_channel_remix_saturating_assert.svh"

module acrs_mix_pipe
    import acrs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      frame_valid,
    output logic      frame_ready,
    input  in_item_t  frame,
    input  ctrl_t     ctrl,
    output logic      remix_valid,
    input  logic      remix_ready,
    output out_item_t remix
);

    logic      st1_valid_reg, st1_valid_next;
    logic      st2_valid_reg, st2_valid_next;
    logic      st3_valid_reg, st3_valid_next;
    in_item_t  st1_item_reg, st1_item_next;
    in_item_t  st2_item_reg, st2_item_next;
    ctrl_t     st1_ctrl_reg, st1_ctrl_next;
    ctrl_t     st2_ctrl_reg, st2_ctrl_next;
    sample_t   st1_l_reg, st1_l_next, st1_r_reg, st1_r_next;
    sample_t   st2_l_reg, st2_l_next, st2_r_reg, st2_r_next;
    out_item_t out_reg, out_next;
    logic      adv1, adv2, adv3;
    sample_t   head;
    sample_t   l_fin, r_fin;

    // a stage may load when it is empty or its content moves on
    assign adv3 = !st3_valid_reg || remix_ready;
    assign adv2 = !st2_valid_reg || adv3;
    assign adv1 = !st1_valid_reg || adv2;

    assign frame_ready = adv1;
    assign remix_valid = st3_valid_reg;
    assign remix       = out_reg;

    assign st1_valid_next = adv1 ? frame_valid   : st1_valid_reg;
    assign st2_valid_next = adv2 ? st1_valid_reg : st2_valid_reg;
    assign st3_valid_next = adv3 ? st2_valid_reg : st3_valid_reg;

    // stage 1: channel 0 to both sides, then channel 1 left and 2 right
    always_comb
    begin
        head          = sat_add(frame.in_ch0, '0);
        st1_item_next = frame;
        st1_ctrl_next = ctrl;
        st1_l_next    = sat_add(head, frame.in_ch1);
        st1_r_next    = sat_add(head, frame.in_ch2);
    end

    // stage 2: channel 3 left, channel 4 right
    always_comb
    begin
        st2_item_next = st1_item_reg;
        st2_ctrl_next = st1_ctrl_reg;
        st2_l_next    = sat_add(st1_l_reg, st1_item_reg.in_ch3);
        st2_r_next    = sat_add(st1_r_reg, st1_item_reg.in_ch4);
    end

    // stage 3: channel 5 to both sides when six source channels are present, then mode select and silencing
    always_comb
    begin
        l_fin = st2_ctrl_reg.add_s5 ? sat_add(st2_l_reg, st2_item_reg.in_ch5) : st2_l_reg;
        r_fin = st2_ctrl_reg.add_s5 ? sat_add(st2_r_reg, st2_item_reg.in_ch5) : st2_r_reg;
        out_next                   = '0;
        out_next.out_channel_count = st2_ctrl_reg.cnt;
        out_next.last_out_block    = st2_item_reg.last_in_block;
        if (!st2_item_reg.silent_frame)
        begin
            unique case (st2_ctrl_reg.eff)
                MODE_DOWNMIX:
                begin
                    out_next.out_ch0 = l_fin;
                    out_next.out_ch1 = r_fin;
                end
                MODE_UPMIX:
                begin
                    out_next.out_ch0 = st2_item_reg.in_ch0;
                    out_next.out_ch2 = st2_item_reg.in_ch1;
                end
                default:
                begin
                    out_next.out_ch0 = st2_ctrl_reg.copy_mask[0] ? st2_item_reg.in_ch0 : '0;
                    out_next.out_ch1 = st2_ctrl_reg.copy_mask[1] ? st2_item_reg.in_ch1 : '0;
                    out_next.out_ch2 = st2_ctrl_reg.copy_mask[2] ? st2_item_reg.in_ch2 : '0;
                    out_next.out_ch3 = st2_ctrl_reg.copy_mask[3] ? st2_item_reg.in_ch3 : '0;
                    out_next.out_ch4 = st2_ctrl_reg.copy_mask[4] ? st2_item_reg.in_ch4 : '0;
                    out_next.out_ch5 = st2_ctrl_reg.copy_mask[5] ? st2_item_reg.in_ch5 : '0;
                end
            endcase
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
        end
        else
        begin
            st1_valid_reg <= st1_valid_next;
            st2_valid_reg <= st2_valid_next;
            st3_valid_reg <= st3_valid_next;
        end
    end

    // stage payloads, loaded only when the stage advances
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            st1_item_reg <= st1_item_next;
            st1_ctrl_reg <= st1_ctrl_next;
            st1_l_reg    <= st1_l_next;
            st1_r_reg    <= st1_r_next;
        end
        if (adv2)
        begin
            st2_item_reg <= st2_item_next;
            st2_ctrl_reg <= st2_ctrl_next;
            st2_l_reg    <= st2_l_next;
            st2_r_reg    <= st2_r_next;
        end
        if (adv3)
        begin
            out_reg <= out_next;
        end
    end

    // a stalled stage keeps its transaction
    `ACRS_ASSERT_NEXT(a_st1_hold, st1_valid_reg && !adv2, st1_valid_reg, "stage 1 lost a transaction")
    `ACRS_ASSERT_NEXT(a_st2_hold, st2_valid_reg && !adv3, st2_valid_reg, "stage 2 lost a transaction")
    // silent frames leave as all zero samples
    `ACRS_ASSERT_NEXT(a_silent, st2_valid_reg && adv3 && st2_item_reg.silent_frame,
        out_reg.out_ch0 == '0 && out_reg.out_ch1 == '0 && out_reg.out_ch2 == '0
            && out_reg.out_ch3 == '0 && out_reg.out_ch4 == '0 && out_reg.out_ch5 == '0,
        "silent frame produced samples")
    // a real downmix always reports stereo
    `ACRS_ASSERT_NOW(a_downmix_cnt, st2_valid_reg && st2_ctrl_reg.eff == MODE_DOWNMIX,
        st2_ctrl_reg.cnt == CNT_STEREO,
        "downmix with a channel count other than two")

endmodule

[hw/rtl/audio_channel_remix_saturating.sv]
// top level of the saturating audio channel remix block
`timescale 1ns / 1ps

// Remixes one frame of six signed 16-bit samples per transaction: surround to
// stereo downmix with each addition clamped to +/-32767, direct copy, or
// stereo to surround. A frame is accepted in every cycle in which the pipe is
// not stalled. The mix pipe has three register stages, through which a frame
// passes in order: the channel 0 and channel 1/2 adds in the first stage, the
// channel 3/4 add in the second, the channel 5 add and mode select in the
// third. Back-pressure on the result side stalls the pipe without loss.
// Registers: mix_mode at byte 0x0, source_channels at 0x4; write them only
// while no frame is in flight.

module audio_channel_remix_saturating
    import acrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frame_valid,
    output logic        frame_ready,
    input  in_item_t    frame,
    output logic        remix_valid,
    input  logic        remix_ready,
    output out_item_t   remix,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0]          mix_mode_reg, mix_mode_next;
    logic [CNT_BITS-1:0] src_ch_reg, src_ch_next;
    logic                wr_en;
    logic [CNT_BITS-1:0] src_cl;
    ctrl_t               ctrl;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register write decode
    always_comb
    begin
        mix_mode_next = mix_mode_reg;
        src_ch_next   = src_ch_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_MIX_MODE:  mix_mode_next = pwdata[1:0];
                REG_SOURCE_CH: src_ch_next   = pwdata[CNT_BITS-1:0];
                default:       mix_mode_next = mix_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_mode_reg <= MODE_COPY;
            src_ch_reg   <= CNT_STEREO;
        end
        else
        begin
            mix_mode_reg <= mix_mode_next;
            src_ch_reg   <= src_ch_next;
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[2])
            REG_MIX_MODE:  prdata = {30'd0, mix_mode_reg};
            REG_SOURCE_CH: prdata = {29'd0, src_ch_reg};
            default:       prdata = '0;
        endcase
    end

    // per-frame control from the configuration
    always_comb
    begin
        if (src_ch_reg < CNT_MIN)
            src_cl = CNT_MIN;
        else if (src_ch_reg > CNT_MAX)
            src_cl = CNT_MAX;
        else
            src_cl = src_ch_reg;

        unique case (mix_mode_reg)
            MODE_DOWNMIX: ctrl.cnt = (src_cl > CNT_STEREO) ? CNT_STEREO : src_cl;
            MODE_UPMIX:   ctrl.cnt = CNT_MAX;
            default:      ctrl.cnt = src_cl;
        endcase

        // fall back to copy when too few source channels are present
        if (mix_mode_reg == MODE_DOWNMIX && src_cl >= CNT_DOWN)
            ctrl.eff = MODE_DOWNMIX;
        else if (mix_mode_reg == MODE_UPMIX && src_cl >= CNT_STEREO)
            ctrl.eff = MODE_UPMIX;
        else
            ctrl.eff = MODE_COPY;

        ctrl.add_s5 = (src_cl == CNT_MAX);
        for (int i = 0; i < NUM_CH; i++)
        begin
            ctrl.copy_mask[i] = (CNT_BITS'(i) < src_cl) && (CNT_BITS'(i) < ctrl.cnt);
        end
    end

    acrs_mix_pipe u_mix_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame),
        .ctrl        (ctrl),
        .remix_valid (remix_valid),
        .remix_ready (remix_ready),
        .remix       (remix)
    );

endmodule
